FILE: rtl/ils_pkg.sv
// Package for the indexed list store: sizes, codes and the cell control bundle.
package ils_pkg;

  localparam int DEPTH  = 64;
  localparam int ELEM_W = 32;
  localparam int POS_W  = 7;
  localparam int CNT_W  = 7;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int KIND_W = 3;
  localparam int STAT_W = 2;
  localparam int IN_DATA_W  = ((POS_W + ELEM_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((ELEM_W + CNT_W + 7) / 8) * 8;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  typedef enum logic [KIND_W-1:0] {
    REQ_PUSH   = 3'd0,
    REQ_POP    = 3'd1,
    REQ_INSERT = 3'd2,
    REQ_REMOVE = 3'd3,
    REQ_GET    = 3'd4,
    REQ_SET    = 3'd5
  } req_kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_WRITE,
    CELL_INSERT,
    CELL_REMOVE
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [POS_W-1:0]  pos;
    logic [ELEM_W-1:0] wdata;
    logic [POS_W-1:0]  rd_pos;
  } cell_ctrl_t;

endpackage

FILE: rtl/ils_cell.sv
// One list slot: holds an entry, shifts from a neighbor, drives the shared read bus.
module ils_cell (
  input  logic                       clk,
  input  logic [ils_pkg::IDX_W-1:0]  idx,
  input  ils_pkg::cell_ctrl_t        ctrl,
  input  logic [ils_pkg::ELEM_W-1:0] prev_value,
  input  logic [ils_pkg::ELEM_W-1:0] next_value,
  output logic [ils_pkg::ELEM_W-1:0] value,
  output logic [ils_pkg::ELEM_W-1:0] rd_term
);

  logic [ils_pkg::POS_W-1:0]  my_pos;
  logic [ils_pkg::ELEM_W-1:0] value_next;

  assign my_pos  = ils_pkg::POS_W'(idx);
  assign rd_term = (my_pos == ctrl.rd_pos) ? value : '0;

  always_comb begin
    value_next = value;
    case (ctrl.op)
      ils_pkg::CELL_WRITE: begin
        if (my_pos == ctrl.pos) value_next = ctrl.wdata;
      end
      ils_pkg::CELL_INSERT: begin
        if (my_pos == ctrl.pos) value_next = ctrl.wdata;
        else if (my_pos > ctrl.pos) value_next = prev_value;
      end
      ils_pkg::CELL_REMOVE: begin
        if (my_pos >= ctrl.pos) value_next = next_value;
      end
      default: value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

FILE: rtl/indexed_list_store_core.sv
// Indexed list store top: request decode, chain of slot cells, output register.
// Latency: a result appears in the cycle after its request is accepted.
// Throughput: one request per cycle while the output is not stalled; every shift, write and
// read finishes in a single pass over the cell chain and the shared read bus.
// Reset (synchronous, active high) empties the list and clears the output valid;
// slot contents are not cleared and are only read after being written.
module indexed_list_store_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [ils_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // position, elem_value, zero pad
  input  logic [ils_pkg::KIND_W-1:0]     s_axis_tuser,  // req_type
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [ils_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // read_value, count, zero pad
  output logic [ils_pkg::STAT_W-1:0]     m_axis_tuser   // status
);

  logic                        accept;
  logic [ils_pkg::POS_W-1:0]   position;
  logic [ils_pkg::ELEM_W-1:0]  elem_value;
  logic [ils_pkg::CNT_W-1:0]   count;
  logic [ils_pkg::CNT_W-1:0]   count_next;
  ils_pkg::status_t            status_next;
  logic                        rd_en;
  logic [ils_pkg::ELEM_W-1:0]  rd_bus;
  ils_pkg::cell_ctrl_t         ctrl;
  ils_pkg::status_t            status;
  logic [ils_pkg::ELEM_W-1:0]  read_value;
  logic [ils_pkg::CNT_W-1:0]   count_out;

  logic [ils_pkg::ELEM_W-1:0] cell_value [ils_pkg::DEPTH];
  logic [ils_pkg::ELEM_W-1:0] cell_rd    [ils_pkg::DEPTH];

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign position      = s_axis_tdata[ils_pkg::POS_W-1:0];
  assign elem_value    = s_axis_tdata[ils_pkg::POS_W +: ils_pkg::ELEM_W];

  always_comb begin
    ctrl.op     = ils_pkg::CELL_HOLD;
    ctrl.pos    = position;
    ctrl.wdata  = elem_value;
    ctrl.rd_pos = position;
    status_next = ils_pkg::ST_OK;
    count_next  = count;
    rd_en       = 1'b0;
    unique case (ils_pkg::req_kind_t'(s_axis_tuser))
      ils_pkg::REQ_PUSH: begin
        if (count == ils_pkg::DEPTH_CNT) begin
          status_next = ils_pkg::ST_FULL;
        end else begin
          ctrl.op    = ils_pkg::CELL_WRITE;
          ctrl.pos   = ils_pkg::POS_W'(count);
          count_next = count + 1'b1;
        end
      end
      ils_pkg::REQ_POP: begin
        if (count == '0) begin
          status_next = ils_pkg::ST_EMPTY;
        end else begin
          ctrl.rd_pos = ils_pkg::POS_W'(count - 1'b1);
          rd_en       = 1'b1;
          count_next  = count - 1'b1;
        end
      end
      ils_pkg::REQ_INSERT: begin
        if (position > ils_pkg::POS_W'(count)) begin
          status_next = ils_pkg::ST_RANGE;
        end else if (count == ils_pkg::DEPTH_CNT) begin
          status_next = ils_pkg::ST_FULL;
        end else begin
          ctrl.op    = ils_pkg::CELL_INSERT;
          count_next = count + 1'b1;
        end
      end
      ils_pkg::REQ_REMOVE: begin
        if (count == '0) begin
          status_next = ils_pkg::ST_EMPTY;
        end else if (position >= ils_pkg::POS_W'(count)) begin
          status_next = ils_pkg::ST_RANGE;
        end else begin
          ctrl.op    = ils_pkg::CELL_REMOVE;
          rd_en      = 1'b1;
          count_next = count - 1'b1;
        end
      end
      ils_pkg::REQ_GET: begin
        if (position >= ils_pkg::POS_W'(count)) status_next = ils_pkg::ST_RANGE;
        else rd_en = 1'b1;
      end
      ils_pkg::REQ_SET: begin
        if (position >= ils_pkg::POS_W'(count)) status_next = ils_pkg::ST_RANGE;
        else ctrl.op = ils_pkg::CELL_WRITE;
      end
      default: begin
        status_next = ils_pkg::ST_OK;
      end
    endcase
    if (!accept) ctrl.op = ils_pkg::CELL_HOLD;
  end

  for (genvar i = 0; i < ils_pkg::DEPTH; i++) begin : g_cell
    logic [ils_pkg::ELEM_W-1:0] prev_value;
    logic [ils_pkg::ELEM_W-1:0] next_value;
    if (i == 0) begin : g_first
      assign prev_value = '0;
    end else begin : g_prev
      assign prev_value = cell_value[i-1];
    end
    if (i == ils_pkg::DEPTH - 1) begin : g_last
      assign next_value = '0;
    end else begin : g_next
      assign next_value = cell_value[i+1];
    end
    ils_cell u_cell (
      .clk        (clk),
      .idx        (ils_pkg::IDX_W'(i)),
      .ctrl       (ctrl),
      .prev_value (prev_value),
      .next_value (next_value),
      .value      (cell_value[i]),
      .rd_term    (cell_rd[i])
    );
  end

  always_comb begin
    rd_bus = '0;
    for (int i = 0; i < ils_pkg::DEPTH; i++) begin
      rd_bus = rd_bus | cell_rd[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        count         <= count_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status     <= status_next;
      read_value <= rd_en ? rd_bus : '0;
      count_out  <= count_next;
    end
  end

  assign m_axis_tdata = {{(ils_pkg::OUT_DATA_W - ils_pkg::ELEM_W - ils_pkg::CNT_W){1'b0}},
                         count_out, read_value};
  assign m_axis_tuser = status;

endmodule
